FILE: src/rs485_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// rs485_frame_receiver_defines
// Assertion macros shared by the frame receiver RTL
// ----------------------------------------------------------------------------
`ifndef RS485_FRAME_RECEIVER_DEFINES_SVH
`define RS485_FRAME_RECEIVER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RSFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define RSFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfr_pkg
// Types and codes of the multidrop frame receiver
// ----------------------------------------------------------------------------
package rsfr_pkg;

	// default sizing
	localparam int NODE_COUNT_DEF = 8;
	localparam int MAX_DATA_DEF   = 64;

	// input transaction kinds
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// frame end status codes
	localparam logic [2:0] ST_NO_REPLY   = 3'd0;
	localparam logic [2:0] ST_WRONG_ADDR = 3'd1;
	localparam logic [2:0] ST_INCOMPLETE = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
	localparam logic [2:0] ST_POLL_OK    = 3'd4;
	localparam logic [2:0] ST_CHECK_ERR  = 3'd5;
	localparam logic [2:0] ST_OVERRUN    = 3'd6;
	localparam logic [2:0] ST_DATA_OK    = 3'd7;

	// register indexes
	localparam logic [1:0] REG_NODE_ROLE = 2'd0;
	localparam logic [1:0] REG_NODE_ADDR = 2'd1;
	localparam logic [1:0] REG_USER_TYPE = 2'd2;

	// receive phase
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ADDR,
		PH_HWSRC,
		PH_TYPE,
		PH_POLLSC,
		PH_SRC,
		PH_DEST,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic       is_address;
		logic [2:0] polled_node;
	} rsfr_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic       frame_type;
		logic [7:0] source_node;
		logic [2:0] dest_node;
		logic [7:0] data_length;
		logic [7:0] master_address;
	} rsfr_out_t;

endpackage

FILE: src/rs485_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_frame_receiver
// Multidrop frame receiver: address, header, data and checksum, one byte per
// transaction, with per-node frame buffers
// ----------------------------------------------------------------------------
// Takes one transaction per clock (start, received byte or timeout) and gives
// at most one result per frame, when the frame ends. Each transaction passes
// an input register, one step of the frame parser, and the result register;
// a new transaction may enter every cycle, and the rate is set only by the
// result register being taken downstream.
// Registers (APB, 4 bytes apart): node_role at 0x0, node_address at 0x4,
// user_type_code at 0x8; write them only while no frame is being received.
// Frame buffers are write-only storage with no clearing after reset.
module rs485_frame_receiver #(
	parameter int NODE_COUNT = rsfr_pkg::NODE_COUNT_DEF,
	parameter int MAX_DATA   = rsfr_pkg::MAX_DATA_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input transactions
	input  logic                in_valid,
	output logic                in_ready,
	input  rsfr_pkg::rsfr_in_t  in_data,
	// result transactions
	output logic                out_valid,
	input  logic                out_ready,
	output rsfr_pkg::rsfr_out_t out_data,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int DATA_AW = $clog2(NODE_COUNT * MAX_DATA);
	localparam int DATA_DEPTH = NODE_COUNT * MAX_DATA;
	localparam logic [7:0] MAX_DATA_B = 8'(MAX_DATA);

	typedef logic [NODE_W-1:0] idx_t;
	typedef idx_t [255:0] mod_tbl_t;

	// byte value modulo node count, built by counting
	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t tbl;
		int       r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			tbl[i] = NODE_W'(r);
			r = (r + 1 == NODE_COUNT) ? 0 : r + 1;
		end
		return tbl;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	// configuration registers
	logic       role_q;
	logic [2:0] addr_q;
	logic       utype_q;

	// input register
	logic               s1_valid_q;
	rsfr_pkg::rsfr_in_t s1_data_q;
	logic               s1_adv;
	logic               proc_fire;

	// parser state
	rsfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]       chk_q, chk_d;
	logic [7:0]       hw_src_q, hw_src_d;
	logic             type_q, type_d;
	logic [7:0]       src_q, src_d;
	idx_t             dest_q, dest_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [7:0]       master_q, master_d;
	idx_t             polled_q, polled_d;
	logic [NODE_COUNT-1:0] buf_full_q, buf_full_d;

	// step outputs
	logic       res_valid;
	logic [2:0] res_status;
	logic       hdr_we;
	logic [4:0] hdr_be;
	idx_t       hdr_idx;
	logic [4:0][7:0] hdr_wdata;
	logic       data_we;
	logic [DATA_AW-1:0] data_addr;
	logic [7:0] rx_b;
	logic       is_master;
	idx_t       own_idx;
	idx_t       target_idx;
	logic [NODE_W+2:0] dest_ext;

	// result register
	logic                out_valid_q;
	rsfr_pkg::rsfr_out_t out_data_q;

	// frame buffers
	logic [4:0][7:0] frame_hdr_mem [NODE_COUNT];
	logic [7:0]      frame_data_mem [DATA_DEPTH];

	// apb register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q  <= 1'b1;
			addr_q  <= 3'd1;
			utype_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				rsfr_pkg::REG_NODE_ROLE: role_q  <= pwdata[0];
				rsfr_pkg::REG_NODE_ADDR: addr_q  <= pwdata[2:0];
				rsfr_pkg::REG_USER_TYPE: utype_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rsfr_pkg::REG_NODE_ROLE: prdata = {31'd0, role_q};
			rsfr_pkg::REG_NODE_ADDR: prdata = {29'd0, addr_q};
			rsfr_pkg::REG_USER_TYPE: prdata = {31'd0, utype_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// input register and flow control
	assign s1_adv    = !out_valid_q || out_ready;
	assign proc_fire = s1_valid_q && s1_adv;
	assign in_ready  = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_data_q <= in_data;
		end
	end

	// node indexes
	assign is_master  = !role_q;
	assign own_idx    = MOD_TBL[8'(addr_q)];
	assign target_idx = is_master ? dest_q : own_idx;
	assign rx_b       = s1_data_q.rx_byte;

	// header bytes and data address
	assign hdr_wdata[0] = hw_src_q;
	assign hdr_wdata[1] = 8'(type_q);
	assign hdr_wdata[2] = src_q;
	assign hdr_wdata[3] = 8'(dest_q);
	assign hdr_wdata[4] = rx_b;
	assign data_addr = DATA_AW'(32'(target_idx) * MAX_DATA + 32'(cnt_q));

	// frame parser step
	always_comb begin
		phase_d    = phase_q;
		chk_d      = chk_q;
		hw_src_d   = hw_src_q;
		type_d     = type_q;
		src_d      = src_q;
		dest_d     = dest_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		master_d   = master_q;
		polled_d   = polled_q;
		buf_full_d = buf_full_q;
		res_valid  = 1'b0;
		res_status = rsfr_pkg::ST_NO_REPLY;
		hdr_we     = 1'b0;
		hdr_be     = 5'b00000;
		hdr_idx    = own_idx;
		data_we    = 1'b0;
		case (s1_data_q.kind)
			rsfr_pkg::KIND_START: begin
				polled_d = MOD_TBL[8'(s1_data_q.polled_node)];
				hw_src_d = 8'd0;
				type_d   = 1'b0;
				src_d    = 8'd0;
				dest_d   = '0;
				len_d    = 8'd0;
				cnt_d    = 8'd0;
				chk_d    = 8'd0;
				phase_d  = rsfr_pkg::PH_ADDR;
			end
			rsfr_pkg::KIND_TIMEOUT: begin
				if (phase_q != rsfr_pkg::PH_IDLE) begin
					res_valid  = 1'b1;
					res_status = (phase_q == rsfr_pkg::PH_ADDR) ?
						rsfr_pkg::ST_NO_REPLY : rsfr_pkg::ST_INCOMPLETE;
					phase_d    = rsfr_pkg::PH_IDLE;
				end
			end
			rsfr_pkg::KIND_BYTE: begin
				case (phase_q)
					rsfr_pkg::PH_IDLE: ;
					rsfr_pkg::PH_ADDR: begin
						if (s1_data_q.is_address) begin
							if (is_master) begin
								buf_full_d[polled_q] = 1'b0;
							end
							if (rx_b == 8'(addr_q)) begin
								chk_d   = 8'(addr_q);
								phase_d = rsfr_pkg::PH_HWSRC;
							end else if (is_master) begin
								res_valid  = 1'b1;
								res_status = rsfr_pkg::ST_WRONG_ADDR;
								phase_d    = rsfr_pkg::PH_IDLE;
							end
						end
					end
					rsfr_pkg::PH_HWSRC: begin
						hw_src_d = rx_b;
						chk_d    = chk_q ^ rx_b;
						if (!is_master) begin
							master_d = rx_b;
						end
						phase_d = rsfr_pkg::PH_TYPE;
					end
					rsfr_pkg::PH_TYPE: begin
						if (|rx_b[7:1]) begin
							res_valid  = 1'b1;
							res_status = rsfr_pkg::ST_BAD_TYPE;
							phase_d    = rsfr_pkg::PH_IDLE;
						end else begin
							chk_d  = chk_q ^ rx_b;
							type_d = rx_b[0];
							if (rx_b[0] != utype_q) begin
								// poll or token: only the sender is kept
								hdr_we  = 1'b1;
								hdr_be  = 5'b00001;
								phase_d = rsfr_pkg::PH_POLLSC;
							end else begin
								phase_d = rsfr_pkg::PH_SRC;
							end
						end
					end
					rsfr_pkg::PH_POLLSC: begin
						res_valid  = 1'b1;
						res_status = (rx_b == chk_q) ?
							rsfr_pkg::ST_POLL_OK : rsfr_pkg::ST_CHECK_ERR;
						phase_d    = rsfr_pkg::PH_IDLE;
					end
					rsfr_pkg::PH_SRC: begin
						src_d   = rx_b;
						chk_d   = chk_q ^ rx_b;
						phase_d = rsfr_pkg::PH_DEST;
					end
					rsfr_pkg::PH_DEST: begin
						chk_d  = chk_q ^ rx_b;
						dest_d = MOD_TBL[rx_b];
						if (is_master && buf_full_q[dest_d]) begin
							res_valid  = 1'b1;
							res_status = rsfr_pkg::ST_OVERRUN;
							phase_d    = rsfr_pkg::PH_IDLE;
						end else begin
							phase_d = rsfr_pkg::PH_LEN;
						end
					end
					rsfr_pkg::PH_LEN: begin
						len_d   = rx_b;
						chk_d   = chk_q ^ rx_b;
						hdr_we  = 1'b1;
						hdr_idx = target_idx;
						hdr_be  = is_master ? 5'b11111 : 5'b10100;
						cnt_d   = 8'd0;
						phase_d = (rx_b == 8'd0) ? rsfr_pkg::PH_SUM : rsfr_pkg::PH_DATA;
					end
					rsfr_pkg::PH_DATA: begin
						// bytes past the buffer size still enter the checksum
						data_we = (cnt_q < MAX_DATA_B);
						chk_d   = chk_q ^ rx_b;
						cnt_d   = cnt_q + 8'd1;
						if (cnt_d == len_q) begin
							phase_d = rsfr_pkg::PH_SUM;
						end
					end
					rsfr_pkg::PH_SUM: begin
						res_valid = 1'b1;
						phase_d   = rsfr_pkg::PH_IDLE;
						if (rx_b == chk_q) begin
							buf_full_d[target_idx] = 1'b1;
							res_status = rsfr_pkg::ST_DATA_OK;
						end else begin
							res_status = rsfr_pkg::ST_CHECK_ERR;
						end
					end
					default: phase_d = rsfr_pkg::PH_IDLE;
				endcase
			end
			default: ;
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rsfr_pkg::PH_IDLE;
			chk_q      <= 8'd0;
			hw_src_q   <= 8'd0;
			type_q     <= 1'b0;
			src_q      <= 8'd0;
			dest_q     <= '0;
			len_q      <= 8'd0;
			cnt_q      <= 8'd0;
			master_q   <= 8'd0;
			polled_q   <= '0;
			buf_full_q <= '0;
		end else if (proc_fire) begin
			phase_q    <= phase_d;
			chk_q      <= chk_d;
			hw_src_q   <= hw_src_d;
			type_q     <= type_d;
			src_q      <= src_d;
			dest_q     <= dest_d;
			len_q      <= len_d;
			cnt_q      <= cnt_d;
			master_q   <= master_d;
			polled_q   <= polled_d;
			buf_full_q <= buf_full_d;
		end
	end

	// frame buffer writes
	always_ff @(posedge clk) begin
		if (proc_fire && hdr_we) begin
			for (int j = 0; j < 5; j++) begin
				if (hdr_be[j]) begin
					frame_hdr_mem[hdr_idx][j] <= hdr_wdata[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire && data_we) begin
			frame_data_mem[data_addr] <= rx_b;
		end
	end

	// result register
	assign dest_ext = (NODE_W + 3)'(dest_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire && res_valid) begin
			out_data_q.status         <= res_status;
			out_data_q.frame_type     <= type_d;
			out_data_q.source_node    <= src_d;
			out_data_q.dest_node      <= dest_ext[2:0];
			out_data_q.data_length    <= len_d;
			out_data_q.master_address <= master_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`include "rs485_frame_receiver_defines.svh"

	`RSFR_ASSERT_SAME(a_stall_holds_s1, out_valid_q && !out_ready, !proc_fire, "parser advanced while result stalled")
	`RSFR_ASSERT_NEXT(a_result_ends_frame, proc_fire && res_valid, phase_q == rsfr_pkg::PH_IDLE, "frame not closed after result")
	`RSFR_ASSERT_SAME(a_idle_exit_by_start, phase_q != rsfr_pkg::PH_IDLE && $past(phase_q) == rsfr_pkg::PH_IDLE, $past(proc_fire) && $past(s1_data_q.kind) == rsfr_pkg::KIND_START, "left idle without start")
	`RSFR_ASSERT_SAME(a_data_count_bound, phase_q == rsfr_pkg::PH_DATA, cnt_q < len_q, "data count reached length in data phase")

endmodule
